>>> rtl/fvsm_pkg.sv
// Shared constants for the four-voice square-wave mixer.
// No dependencies; imported by four_voice_square_mixer.
`default_nettype none

package fvsm_pkg;

  // Field widths
  localparam int OPCODE_W = 1;
  localparam int VOICE_W  = 2;
  localparam int PITCH_W  = 12;
  localparam int SAMPLE_W = 8;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_NOTE   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

  // Audio rate and square amplitude
  localparam int RATE_HZ    = 8000;
  localparam int FULL_LEVEL = 255;

  // Position counter and divider geometry
  localparam int POS_W     = 24;
  localparam int PERIOD_W  = 13;   // 8000 / f fits in 13 bits
  localparam int DIV_STEPS = POS_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Parameter defaults
  localparam int VOICES_DEF    = 4;
  localparam int BLOCK_LEN_DEF = 256;

endpackage

`default_nettype wire

>>> rtl/four_voice_square_mixer.sv
// Four-voice square-wave PCM mixer with one shared restoring divider.
// Note beat: busy while the divider computes the period (not busy when pitch is zero or voice out of range).
// Sample beat: busy while LOAD walks the voices, dividing (DIV, MIX) for each active one and skipping
// each silent one, then FIN registers the result, later while out_stall holds the last one.
// Reset (rst_n, synchronous): all voices silent, position zero, no result pending.
// Depends on fvsm_pkg.
`default_nettype none

module four_voice_square_mixer #(
  parameter int VOICES    = fvsm_pkg::VOICES_DEF,
  parameter int BLOCK_LEN = fvsm_pkg::BLOCK_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fvsm_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [fvsm_pkg::VOICE_W-1:0]  in_voice,
  input  wire logic [fvsm_pkg::PITCH_W-1:0]  in_pitch,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fvsm_pkg::SAMPLE_W-1:0]      out_sample,
  output logic                               out_block_end
);
  import fvsm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int BW = $clog2(BLOCK_LEN);
  localparam logic [BW-1:0] BLK_LAST = BW'(BLOCK_LEN - 1);
  localparam logic [CW-1:0] VCNT_END = CW'(VOICES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic                note_r, note_nxt;      // divider computes a period
  logic [VW-1:0]       tgt_r, tgt_nxt;
  logic [CW-1:0]       vcnt_r, vcnt_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [POS_W-1:0]    dvd_r, dvd_nxt;        // dividend, then quotient
  logic [PERIOD_W-1:0] dvs_r, dvs_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [BW-1:0]       blk_r, blk_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                out_end_r, out_end_nxt;
  logic [PERIOD_W-1:0] period_r   [VOICES];
  logic [PERIOD_W-1:0] period_nxt [VOICES];

  logic                in_acc, out_take, out_free;
  logic [VW-1:0]       vidx;
  logic [PERIOD_W-1:0] cur_period;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W+1:0] diff;
  logic                ge;
  logic [SAMPLE_W-1:0] level;
  logic [SAMPLE_W:0]   sum;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_take   = out_valid_r && !out_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign vidx       = vcnt_r[VW-1:0];
  assign cur_period = period_r[vidx];

  // One restoring step: shift in the next dividend bit, try the subtract.
  assign trial = {rem_r, dvd_r[POS_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = !diff[PERIOD_W+1];

  assign level = (rem_r > (dvs_r >> 1)) ? SAMPLE_W'(FULL_LEVEL) : '0;
  assign sum   = {1'b0, acc_r} + {1'b0, level};

  always_comb begin
    state_nxt      = state_r;
    note_nxt       = note_r;
    tgt_nxt        = tgt_r;
    vcnt_nxt       = vcnt_r;
    step_nxt       = step_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    rem_nxt        = rem_r;
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    blk_nxt        = blk_r;
    out_valid_nxt  = out_valid_r && !out_take;
    out_sample_nxt = out_sample_r;
    out_end_nxt    = out_end_r;
    for (int v = 0; v < VOICES; v++) begin
      period_nxt[v] = period_r[v];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_NOTE) begin
            tgt_nxt = VW'(in_voice);
            if (32'(in_voice) < VOICES) begin
              if (in_pitch == '0) begin
                period_nxt[VW'(in_voice)] = '0;
              end else begin
                note_nxt  = 1'b1;
                dvd_nxt   = POS_W'(RATE_HZ);
                dvs_nxt   = PERIOD_W'(in_pitch);
                rem_nxt   = '0;
                step_nxt  = STEP_W'(DIV_STEPS - 1);
                state_nxt = ST_DIV;
              end
            end
          end else begin
            note_nxt  = 1'b0;
            vcnt_nxt  = '0;
            acc_nxt   = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (vcnt_r == VCNT_END) begin
          state_nxt = ST_FIN;
        end else if (cur_period == '0) begin
          vcnt_nxt = vcnt_r + 1'b1;
        end else begin
          dvd_nxt   = pos_r;
          dvs_nxt   = cur_period;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(DIV_STEPS - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        dvd_nxt  = {dvd_r[POS_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (note_r) begin
            period_nxt[tgt_r] = PERIOD_W'({dvd_r[POS_W-2:0], ge});
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        // voice 0 seeds the mix, later voices average in
        acc_nxt   = (vcnt_r == '0) ? level : sum[SAMPLE_W:1];
        vcnt_nxt  = vcnt_r + 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = (acc_r == '0) ? SAMPLE_W'(1) : acc_r;
          out_end_nxt    = (blk_r == BLK_LAST);
          pos_nxt        = pos_r + 1'b1;
          // block count restarts on position wrap as well
          blk_nxt        = ((blk_r == BLK_LAST) || (pos_r == '1)) ? '0 : blk_r + 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      blk_r       <= '0;
      for (int v = 0; v < VOICES; v++) begin
        period_r[v] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      blk_r       <= blk_nxt;
      for (int v = 0; v < VOICES; v++) begin
        period_r[v] <= period_nxt[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    note_r       <= note_nxt;
    tgt_r        <= tgt_nxt;
    vcnt_r       <= vcnt_nxt;
    step_r       <= step_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    rem_r        <= rem_nxt;
    acc_r        <= acc_nxt;
    out_sample_r <= out_sample_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_block_end = out_end_r;

endmodule

`default_nettype wire

>>> bench/four_voice_square_mixer_tb.sv
`timescale 1ns / 1ps
// Testbench for four_voice_square_mixer: directed and random note/sample beats.
// A scoreboard class mixes its own copy of the voices and checks each sample beat.
// Depends on fvsm_pkg and the mixer RTL.

module four_voice_square_mixer_tb;
  import fvsm_pkg::*;

  localparam int VOICES       = VOICES_DEF;
  localparam int BLOCK_LEN    = BLOCK_LEN_DEF;
  localparam int RANDOM_BEATS = 800;
  localparam int HANG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                block_end;
  } mix_result_t;

  class mixer_scoreboard;
    logic [PITCH_W-1:0] voice_freq [VOICES];
    logic [POS_W-1:0]   position;
    mix_result_t        expected_samples [$];
    int                 errors;
    int                 checked;

    function new();
      foreach (voice_freq[i]) voice_freq[i] = '0;
      position = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function logic [SAMPLE_W-1:0] square_level(logic [POS_W-1:0] pos,
                                               logic [PITCH_W-1:0] freq);
      int unsigned period;
      period = RATE_HZ / freq;   // freq <= 4095, so period >= 1
      return ((pos % period) > (period / 2)) ? SAMPLE_W'(FULL_LEVEL) : '0;
    endfunction

    // Accepted input beat: note beats update a voice, sample beats queue a result.
    function void note_beat(logic [OPCODE_W-1:0] op, logic [VOICE_W-1:0] v,
                            logic [PITCH_W-1:0] freq);
      int unsigned acc;
      mix_result_t r;
      if (op == OP_NOTE) begin
        if (v < VOICES) voice_freq[v] = freq;
        return;
      end
      acc = 0;
      if (voice_freq[0] != 0) acc = square_level(position, voice_freq[0]);
      // silent voices stay out of the averaging
      for (int i = 1; i < VOICES; i++) begin
        if (voice_freq[i] != 0) acc = (acc + square_level(position, voice_freq[i])) / 2;
      end
      if (acc == 0) acc = 1;
      r.sample    = SAMPLE_W'(acc);
      r.block_end = ((position % BLOCK_LEN) == BLOCK_LEN - 1);
      expected_samples.push_back(r);
      position = position + 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_sample(logic [SAMPLE_W-1:0] sample, logic block_end);
      mix_result_t want;
      checked++;
      if (expected_samples.size() == 0) begin
        report($sformatf("sample beat %0d (%0d) with nothing expected", checked, sample));
        return;
      end
      want = expected_samples.pop_front();
      if (sample !== want.sample)
        report($sformatf("sample beat %0d: sample %0d, expected %0d",
                         checked, sample, want.sample));
      if (block_end !== want.block_end)
        report($sformatf("sample beat %0d: block_end %0b, expected %0b",
                         checked, block_end, want.block_end));
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode = OP_NOTE;
  logic [VOICE_W-1:0]  in_voice  = '0;
  logic [PITCH_W-1:0]  in_pitch  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_block_end;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hang_count    = 0;

  mixer_scoreboard sb = new();

  four_voice_square_mixer #(
    .VOICES    (VOICES),
    .BLOCK_LEN (BLOCK_LEN)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_voice      (in_voice),
    .in_pitch      (in_pitch),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_block_end (out_block_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_beat(in_opcode, in_voice, in_pitch);
    if (rst_n && out_valid && !out_stall) sb.check_sample(out_sample, out_block_end);
  end

  // Watchdog: cycles in a row with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
  end

  // valid is lowered only for an idle gap, so a held valid is never toggled in one step
  task automatic drive_beat(input logic [OPCODE_W-1:0] op, input logic [VOICE_W-1:0] v,
                            input logic [PITCH_W-1:0] freq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_voice  <= v;
    in_pitch  <= freq;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_beat();
    logic [OPCODE_W-1:0] op;
    logic [VOICE_W-1:0]  v;
    logic [PITCH_W-1:0]  freq;
    int                  pick;
    op   = ($urandom_range(99) < 75) ? OP_SAMPLE : OP_NOTE;
    v    = VOICE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 20)      freq = '0;
    else if (pick < 30) freq = PITCH_W'($urandom_range(13, 1));      // very long periods
    else if (pick < 80) freq = PITCH_W'($urandom_range(400, 14));
    else                freq = PITCH_W'($urandom_range(4095, 401));  // short periods
    drive_beat(op, v, freq);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats, no idling
    drive_beat(OP_SAMPLE, '0, '0);            // all voices silent
    drive_beat(OP_NOTE, 2'd0, 12'd2000);      // period 4
    drive_beat(OP_SAMPLE, 2'd3, 12'hFFF);     // unused fields on a sample beat
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_NOTE, 2'd1, 12'd2667);      // period 2, always low
    drive_beat(OP_NOTE, 2'd2, 12'hFFF);       // period 1
    drive_beat(OP_NOTE, 2'd3, 12'd1);         // longest period
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_NOTE, 2'd0, '0);            // voice 0 silent, others still mix
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_SAMPLE, '0, '0);
    drive_beat(OP_NOTE, 2'd1, '0);
    drive_beat(OP_NOTE, 2'd2, '0);
    drive_beat(OP_NOTE, 2'd3, '0);
    drive_beat(OP_SAMPLE, '0, '0);            // silent again
    drive_beat(OP_NOTE, 2'd3, 12'd250);       // lone high voice
    drive_beat(OP_SAMPLE, '0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      repeat (RANDOM_BEATS / 4) random_beat();
    end
    in_valid <= 1'b0;

    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_samples.size() != 0)
      sb.report($sformatf("%0d samples never arrived", sb.expected_samples.size()));

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
